/* hdl/bounded_deque_with_search_defines.svh */
// Assertion macros for the bounded deque block.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while in reset
`define BDQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while in reset
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BDQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hdl/bdq_pkg.sv */
package bdq_pkg;

    // Command codes
    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_SEARCH     = 3'd4
    } cmd_code_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_REPLY
    } bdq_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic apply;
        logic scan_start;
        logic scan_step;
        logic reply;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_search;
        logic empty;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

/* hdl/bdq_ram.sv */
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/bdq_ctrl.sv */
module bdq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  bdq_pkg::dp_stat_t    stat,
    output bdq_pkg::ctrl_cmd_t   ctl
);

    import bdq_pkg::*;

    bdq_state_t state_reg;
    bdq_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.is_search && !stat.empty)
                begin
                    ctl.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else
                begin
                    ctl.apply  = 1'b1;
                    state_next = S_REPLY;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    ctl.reply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/bdq_dp.sv */
module bdq_dp #(
    parameter int CAPACITY = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bdq_pkg::ctrl_cmd_t   ctl,
    output bdq_pkg::dp_stat_t    stat,
    input  logic [2:0]           cmd,
    input  logic signed [31:0]   item_value,
    output logic [1:0]           status,
    output logic                 found,
    output logic [3:0]           match_position,
    output logic [4:0]           element_count,
    output logic                 result_valid,
    input  logic                 result_stall
);

    import bdq_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // Captured command word
    logic [2:0]    cmd_reg;
    logic [31:0]   val_reg;

    // List pointers
    logic [AW-1:0] front_reg;
    logic [AW-1:0] front_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // Pending result
    status_t       res_status_reg;
    status_t       res_status_next;
    logic          res_found_reg;
    logic [AW-1:0] res_pos_reg;

    // Scan pipeline
    logic [CW-1:0] rd_off_reg;
    logic          cmp_valid_reg;
    logic [AW-1:0] cmp_off_reg;

    // Output word
    logic [1:0]    status_out_reg;
    logic          found_out_reg;
    logic [3:0]    pos_out_reg;
    logic [4:0]    count_out_reg;
    logic          result_valid_reg;

    logic          full;
    logic          empty;
    logic [AW-1:0] prev_front;
    logic [AW-1:0] next_front;
    logic [AW:0]   back_sum;
    logic [AW-1:0] back_slot;
    logic [AW:0]   scan_sum;
    logic [AW-1:0] scan_slot;
    logic          issue;
    logic          hit;
    logic          last;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_rdata;
    logic [AW+3:0] pos_wide;
    logic [CW+4:0] count_wide;

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    // Ring arithmetic: step back, step forward, offset from front
    assign prev_front = (front_reg == '0) ? AW'(CAPACITY - 1) : front_reg - AW'(1);
    assign next_front = (front_reg == AW'(CAPACITY - 1)) ? '0 : front_reg + AW'(1);
    assign back_sum   = {1'b0, front_reg} + {1'b0, count_reg[AW-1:0]};
    assign back_slot  = (back_sum >= (AW+1)'(CAPACITY))
                      ? AW'(back_sum - (AW+1)'(CAPACITY)) : back_sum[AW-1:0];
    assign scan_sum   = {1'b0, front_reg} + {1'b0, rd_off_reg[AW-1:0]};
    assign scan_slot  = (scan_sum >= (AW+1)'(CAPACITY))
                      ? AW'(scan_sum - (AW+1)'(CAPACITY)) : scan_sum[AW-1:0];

    // Scan: issue one read per cycle, compare the word that returns
    assign issue = ctl.scan_step && (rd_off_reg < count_reg);
    assign hit   = cmp_valid_reg && (ram_rdata == val_reg);
    assign last  = cmp_valid_reg && ((CW'(cmp_off_reg) + CW'(1)) == count_reg);

    // Status to controller
    assign stat.is_search = (cmd_reg == CMD_SEARCH);
    assign stat.empty     = empty;
    assign stat.scan_done = hit || last;
    assign stat.out_free  = !result_valid_reg || !result_stall;

    // Push, pop and status decode
    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        res_status_next = ST_DONE;
        ram_we          = 1'b0;
        ram_waddr       = back_slot;
        case (cmd_reg)
            CMD_PUSH_FRONT:
            begin
                ram_waddr = prev_front;
                if (full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    ram_we     = ctl.apply;
                    front_next = prev_front;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    ram_we     = ctl.apply;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    front_next = next_front;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_POP_BACK:
            begin
                if (empty)
                begin
                    res_status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                res_status_next = ST_DONE;
            end
        endcase
    end

    // Element store
    bdq_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (val_reg),
        .re    (issue),
        .raddr (scan_slot),
        .rdata (ram_rdata)
    );

    // Capture the incoming word
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg <= cmd;
            val_reg <= item_value;
        end
    end

    // List pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (ctl.apply)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // Scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_off_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= issue;
            if (ctl.scan_start)
            begin
                rd_off_reg <= '0;
            end
            else if (issue)
            begin
                rd_off_reg <= rd_off_reg + CW'(1);
            end
        end
    end

    // Track offset of the word in flight, and hold the pending result
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmp_off_reg <= rd_off_reg[AW-1:0];
        end
        if (ctl.apply || ctl.scan_start)
        begin
            res_status_reg <= ctl.apply ? res_status_next : ST_DONE;
            res_found_reg  <= 1'b0;
            res_pos_reg    <= '0;
        end
        else if (ctl.scan_step && hit)
        begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= cmp_off_reg;
        end
    end

    assign pos_wide   = (AW+4)'(res_pos_reg);
    assign count_wide = (CW+5)'(count_reg);

    // Output word
    always_ff @(posedge clk)
    begin
        if (ctl.reply)
        begin
            status_out_reg <= res_status_reg;
            found_out_reg  <= res_found_reg;
            pos_out_reg    <= pos_wide[3:0];
            count_out_reg  <= count_wide[4:0];
        end
    end

    // Output valid: set on load, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (ctl.reply)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    assign status         = status_out_reg;
    assign found          = found_out_reg;
    assign match_position = pos_out_reg;
    assign element_count  = count_out_reg;
    assign result_valid   = result_valid_reg;

endmodule

/* hdl/bounded_deque_with_search.sv */
// Bounded double-ended queue of signed 32-bit words with a linear search.
// Input channel (item_valid / item_stall) carries cmd and item_value; the
// output channel (result_valid / result_stall) returns status, found,
// match_position and element_count, one result word per input word.
// Commands: push front, push back, pop front, pop back, search; other codes
// are ignored and report the current count. Push on a full store reports
// full, pop on an empty list reports empty, neither changes the list.
// Push, pop, ignored commands and a search of an empty list: the word is
// captured on accept, applied in S_EXEC and loaded into the output register
// in S_REPLY; the next word is accepted once that reply has gone out.
// Search: the store is a RAM with a registered read, read one slot a cycle
// from the front and compared as each word returns; the scan stops at the
// first match (position p from the front) or after all n held elements (n > 0).
// The result sits in an output register, so a stalled receiver does not
// stop the next word from being accepted and executed; only its reply
// waits until the output register frees up.
// Reset empties the list and clears the front pointer; the store contents
// are not cleared and need no clearing pass.
`include "bounded_deque_with_search_defines.svh"

module bounded_deque_with_search #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         cmd,
    input  logic signed [31:0] item_value,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         status,
    output logic               found,
    output logic [3:0]         match_position,
    output logic [4:0]         element_count
);

    import bdq_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    bdq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .ctl        (ctl)
    );

    bdq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .stat           (stat),
        .cmd            (cmd),
        .item_value     (item_value),
        .status         (status),
        .found          (found),
        .match_position (match_position),
        .element_count  (element_count),
        .result_valid   (result_valid),
        .result_stall   (result_stall)
    );

    // Block goes busy right after taking a word
    `BDQ_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "not busy")
    // A reply always shows up on the output
    `BDQ_ASSERT_NEXT(a_reply_valid, ctl.reply, result_valid, "reply not presented")
    // Accept and reply never coincide
    `BDQ_ASSERT_IMPL(a_accept_not_reply, item_valid && !item_stall, !ctl.reply, "accept at reply")

endmodule
